// ----- hw/rtl/nsf_pkg.sv -----
// Shared types and constants for the sentence framer.
// Used by the controller, the datapath and the top level; depends on nothing.
package nsf_pkg;

	// Default sizing of the sentence store and the term limit.
	localparam int unsigned BufferLenDefault   = 64;
	localparam int unsigned MaxTermCountDefault = 24;

	// Width of a term counter and of the term index field.
	localparam int unsigned TermW = 5;

	// Controller states.
	typedef enum logic [1:0] {
		MODE_WAIT   = 2'd0,
		MODE_TERM   = 2'd1,
		MODE_CHECK  = 2'd2,
		MODE_REPLAY = 2'd3
	} mode_t;

	// Status codes carried by each result item.
	typedef enum logic [1:0] {
		STATUS_BYTE     = 2'd0,
		STATUS_MISMATCH = 2'd1,
		STATUS_OVERFLOW = 2'd2,
		STATUS_TERMS    = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    clear;
		logic    store_byte;
		logic    store_sep;
		logic    count_term;
		logic    xor_byte;
		logic    check_start;
		logic    check_digit;
		logic    replay_start;
		logic    replay_emit;
		logic    emit_status;
		status_t status_code;
	} cmd_t;

	// Status flags from the datapath to the controller.
	typedef struct packed {
		logic is_dollar;
		logic is_eol;
		logic is_comma;
		logic is_star;
		logic buf_full;
		logic terms_full;
		logic check_ok;
		logic replay_last;
		logic out_free;
	} flags_t;

endpackage

// ----- hw/rtl/nsf_ctrl.sv -----
// Controller state machine of the sentence framer.
// Depends on nsf_pkg; drives commands to nsf_datapath and the input stall.
module nsf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  nsf_pkg::flags_t flags,
	output nsf_pkg::cmd_t   cmd
);

	nsf_pkg::mode_t state_q;
	nsf_pkg::mode_t state_d;
	logic           in_fire;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsf_pkg::MODE_WAIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Input is held off during replay and while the result slot is blocked.
	assign in_stall = (state_q == nsf_pkg::MODE_REPLAY) || !flags.out_free;
	assign in_fire  = in_valid && !in_stall;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			nsf_pkg::MODE_WAIT: begin
				if (in_fire && flags.is_dollar) begin
					cmd.clear = 1'b1;
					state_d   = nsf_pkg::MODE_TERM;
				end
			end
			nsf_pkg::MODE_TERM: begin
				if (in_fire) begin
					if (flags.is_eol) begin
						state_d = nsf_pkg::MODE_WAIT;
					end else if (flags.buf_full) begin
						cmd.emit_status = 1'b1;
						cmd.status_code = nsf_pkg::STATUS_OVERFLOW;
						state_d         = nsf_pkg::MODE_WAIT;
					end else if (flags.is_comma || flags.is_star) begin
						cmd.store_sep = 1'b1;
						if (flags.terms_full) begin
							cmd.emit_status = 1'b1;
							cmd.status_code = nsf_pkg::STATUS_TERMS;
							state_d         = nsf_pkg::MODE_WAIT;
						end else begin
							cmd.count_term = 1'b1;
							if (flags.is_star) begin
								cmd.check_start = 1'b1;
								state_d         = nsf_pkg::MODE_CHECK;
							end else begin
								cmd.xor_byte = 1'b1;
							end
						end
					end else begin
						cmd.store_byte = 1'b1;
						cmd.xor_byte   = 1'b1;
					end
				end
			end
			nsf_pkg::MODE_CHECK: begin
				if (in_fire) begin
					if (flags.is_eol || flags.is_comma || flags.is_star) begin
						if (flags.check_ok) begin
							cmd.replay_start = 1'b1;
							state_d          = nsf_pkg::MODE_REPLAY;
						end else begin
							cmd.emit_status = 1'b1;
							cmd.status_code = nsf_pkg::STATUS_MISMATCH;
							state_d         = nsf_pkg::MODE_WAIT;
						end
					end else begin
						cmd.check_digit = 1'b1;
					end
				end
			end
			nsf_pkg::MODE_REPLAY: begin
				if (flags.out_free) begin
					cmd.replay_emit = 1'b1;
					if (flags.replay_last) begin
						state_d = nsf_pkg::MODE_WAIT;
					end
				end
			end
			default: begin
				state_d = nsf_pkg::MODE_WAIT;
			end
		endcase
	end

endmodule

// ----- hw/rtl/nsf_datapath.sv -----
// Datapath of the sentence framer: character decode, counters, parity,
// checksum digits, sentence store and result register. Depends on nsf_pkg.
module nsf_datapath #(
	parameter int unsigned BUFFER_LEN     = nsf_pkg::BufferLenDefault,
	parameter int unsigned MAX_TERM_COUNT = nsf_pkg::MaxTermCountDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 rx_byte,
	input  nsf_pkg::cmd_t              cmd,
	output nsf_pkg::flags_t            flags,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_byte,
	output logic [nsf_pkg::TermW-1:0]  term_index,
	output logic                       separator_mark,
	output logic [1:0]                 status,
	output logic                       last
);

	localparam int unsigned PtrW  = $clog2(BUFFER_LEN + 1);
	localparam int unsigned AddrW = $clog2(BUFFER_LEN);

	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChComma  = 8'h2C;
	localparam logic [7:0] ChStar   = 8'h2A;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChLf     = 8'h0A;

	logic [PtrW-1:0]          wp_q;
	logic [nsf_pkg::TermW-1:0] tc_q;
	logic [7:0]               parity_q;
	logic [7:0]               check_q;
	logic [1:0]               digits_q;
	logic [PtrW-1:0]          idx_q;
	logic [nsf_pkg::TermW-1:0] ti_q;
	logic [8:0]               store_q [BUFFER_LEN];
	logic [8:0]               rdata_q;
	logic                     is_hex;
	logic [3:0]               hex_val;
	logic                     rd_en;
	logic [PtrW-1:0]          rd_ptr;
	logic [PtrW-1:0]          idx_next;
	logic                     out_valid_q;
	logic [7:0]               out_byte_q;
	logic [nsf_pkg::TermW-1:0] term_index_q;
	logic                     sep_q;
	logic [1:0]               status_q;
	logic                     last_q;

	// Hex digit decode of the incoming character.
	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
			hex_val = 4'(rx_byte - 8'h30);
		end else if (rx_byte >= 8'h61 && rx_byte <= 8'h66) begin
			hex_val = 4'(rx_byte - 8'h57);
		end else if (rx_byte >= 8'h41 && rx_byte <= 8'h46) begin
			hex_val = 4'(rx_byte - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	// Status flags for the controller.
	assign idx_next = idx_q + PtrW'(1);
	always_comb begin
		flags.is_dollar   = (rx_byte == ChDollar);
		flags.is_eol      = (rx_byte == ChCr) || (rx_byte == ChLf);
		flags.is_comma    = (rx_byte == ChComma);
		flags.is_star     = (rx_byte == ChStar);
		flags.buf_full    = (wp_q >= PtrW'(BUFFER_LEN));
		flags.terms_full  = (tc_q >= nsf_pkg::TermW'(MAX_TERM_COUNT));
		flags.check_ok    = ((digits_q == 2'd1) || (digits_q == 2'd2)) &&
			(check_q == parity_q);
		flags.replay_last = (idx_next == wp_q);
		flags.out_free    = !out_valid_q || !out_stall;
	end

	// Write pointer, term count and running parity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			tc_q     <= '0;
			parity_q <= '0;
		end else begin
			if (cmd.clear) begin
				wp_q     <= '0;
				tc_q     <= '0;
				parity_q <= '0;
			end else begin
				if (cmd.store_byte || cmd.store_sep) begin
					wp_q <= wp_q + PtrW'(1);
				end
				if (cmd.count_term) begin
					tc_q <= tc_q + nsf_pkg::TermW'(1);
				end
				if (cmd.xor_byte) begin
					parity_q <= parity_q ^ rx_byte;
				end
			end
		end
	end

	// Checksum digit collection; a non-hex byte closes the field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_q  <= '0;
			digits_q <= '0;
		end else if (cmd.check_start) begin
			check_q  <= '0;
			digits_q <= '0;
		end else if (cmd.check_digit && (digits_q < 2'd2)) begin
			if (is_hex) begin
				check_q  <= {check_q[3:0], hex_val};
				digits_q <= digits_q + 2'd1;
			end else begin
				digits_q <= (digits_q == 2'd0) ? 2'd3 : 2'd2;
			end
		end
	end

	// Sentence store: written while terms arrive, read during replay.
	assign rd_en  = cmd.replay_start || (cmd.replay_emit && !flags.replay_last);
	assign rd_ptr = cmd.replay_start ? '0 : idx_next;

	always_ff @(posedge clk) begin
		if (cmd.store_byte || cmd.store_sep) begin
			store_q[wp_q[AddrW-1:0]] <= cmd.store_sep ? 9'h100 : {1'b0, rx_byte};
		end
		if (rd_en) begin
			rdata_q <= store_q[rd_ptr[AddrW-1:0]];
		end
	end

	// Replay position and term index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ti_q  <= '0;
		end else if (cmd.replay_start) begin
			idx_q <= '0;
			ti_q  <= '0;
		end else if (cmd.replay_emit) begin
			idx_q <= idx_next;
			if (rdata_q[8]) begin
				ti_q <= ti_q + nsf_pkg::TermW'(1);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_status || cmd.replay_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_status) begin
			out_byte_q   <= '0;
			term_index_q <= '0;
			sep_q        <= 1'b0;
			status_q     <= cmd.status_code;
			last_q       <= 1'b1;
		end else if (cmd.replay_emit) begin
			out_byte_q   <= rdata_q[7:0];
			term_index_q <= ti_q;
			sep_q        <= rdata_q[8];
			status_q     <= nsf_pkg::STATUS_BYTE;
			last_q       <= flags.replay_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign term_index     = term_index_q;
	assign separator_mark = sep_q;
	assign status         = status_q;
	assign last           = last_q;

endmodule

// ----- hw/rtl/nmea_sentence_framer_top.sv -----
// Top level of the sentence framer: controller plus datapath.
// Depends on nsf_pkg, nsf_ctrl and nsf_datapath.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  rx_byte
//   output   out_valid / out_stall out_byte, term_index, separator_mark,
//                                 status, last
//
// The block stalls input while the result register is full and held, and for
// the whole of a replay. A good checksum starts a replay of the stored
// entries: the first entry is read from the store as the closing byte is
// taken and then passes to the result register; the rest follow one per cycle
// from the single read port of the sentence store while the output is not stalled.
// Output stalls pause the replay. Reset clears the controller and counters;
// the store needs no clearing since replay reads only freshly written entries.
module nmea_sentence_framer_top #(
	parameter int unsigned BUFFER_LEN     = nsf_pkg::BufferLenDefault,
	parameter int unsigned MAX_TERM_COUNT = nsf_pkg::MaxTermCountDefault
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                rx_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                out_byte,
	output logic [nsf_pkg::TermW-1:0] term_index,
	output logic                      separator_mark,
	output logic [1:0]                status,
	output logic                      last
);

	nsf_pkg::cmd_t   cmd;
	nsf_pkg::flags_t flags;

	nsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.flags    (flags),
		.cmd      (cmd)
	);

	nsf_datapath #(
		.BUFFER_LEN     (BUFFER_LEN),
		.MAX_TERM_COUNT (MAX_TERM_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.flags          (flags),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.term_index     (term_index),
		.separator_mark (separator_mark),
		.status         (status),
		.last           (last)
	);

endmodule

// ----- hw/rtl/nsf_checker.sv -----
// Port-level checks of the sentence framer, bound to the top level.
// Depends on the top level's ports and the status codes of nsf_pkg.
module nsf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic [4:0] term_index,
	input logic       separator_mark,
	input logic [1:0] status,
	input logic       last
);

	// A held result keeps its byte, term index, status and last flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) &&
		$stable(term_index) && $stable(status) && $stable(last))
		else $error("held result changed");

	// An error status is a lone result with empty payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != nsf_pkg::STATUS_BYTE) |-> last && (out_byte == 8'd0) &&
		(term_index == 5'd0) && !separator_mark)
		else $error("status result malformed");

	// Only a replayed sentence yields a run longer than one item.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> (status == nsf_pkg::STATUS_BYTE))
		else $error("error status inside a run");

	// Input stays blocked while a replay run is still going.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input taken during replay");

endmodule

bind nmea_sentence_framer_top nsf_checker u_nsf_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for nmea_sentence_framer_top: framed byte streams in,
// replayed entries and status results out, predicted per accepted item.
// Depends on nsf_pkg and the framer RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned BUF_LEN    = nsf_pkg::BufferLenDefault;
	localparam int unsigned TERM_LIMIT = nsf_pkg::MaxTermCountDefault;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	// Digit counter value for a checksum field closed before any hex digit.
	localparam logic [1:0] DIGITS_NONE = 2'd3;

	// Stress hold on the output side, in cycles.
	localparam int HOLD_CYCLES = 150;
	// The last stretch of the run has no random gaps on the input side.
	localparam int QUIET_TAIL  = 40;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0]                data;
		logic [nsf_pkg::TermW-1:0] term;
		logic                      sep;
		nsf_pkg::status_t          st;
		logic                      last;
	} framer_result_t;

	typedef enum int {
		CK_GOOD,
		CK_GOOD_ONE,
		CK_EXTRA,
		CK_BAD,
		CK_NONE,
		CK_DROP
	} check_style_t;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic [7:0]                rx_byte   = 8'h00;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [7:0]                out_byte;
	logic [nsf_pkg::TermW-1:0] term_index;
	logic                      separator_mark;
	logic [1:0]                status;
	logic                      last;

	nmea_sentence_framer_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.term_index     (term_index),
		.separator_mark (separator_mark),
		.status         (status),
		.last           (last)
	);

	// Bytes waiting to be sent and results waiting to be seen.
	logic [7:0]     tx_bytes[$];
	framer_result_t sentence_results[$];

	int error_count   = 0;
	int results_seen  = 0;
	logic [7:0] gen_parity;

	// Shadow of the framer state.
	nsf_pkg::mode_t fr_mode;
	int             fr_wp;
	int             fr_terms;
	logic [7:0]     fr_parity;
	logic [7:0]     fr_check;
	logic [1:0]     fr_digits;
	logic [8:0]     fr_store[BUF_LEN];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return c - "0";
		if (c >= "a" && c <= "f")
			return c - "a" + 10;
		if (c >= "A" && c <= "F")
			return c - "A" + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10)
			return 8'h30 + {4'h0, v};
		return (upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
	endfunction

	function automatic bit is_terminator(input logic [7:0] c);
		return c == CH_CR || c == CH_LF || c == CH_COMMA || c == CH_STAR;
	endfunction

	// A status result ends the sentence and returns the framer to waiting.
	task automatic push_status(input nsf_pkg::status_t code);
		framer_result_t r;
		r = '{data: 8'h00, term: '0, sep: 1'b0, st: code, last: 1'b1};
		sentence_results.push_back(r);
		fr_mode = nsf_pkg::MODE_WAIT;
	endtask

	// Advance the shadow state by one received byte and queue what it causes.
	task automatic track_sentence_byte(input logic [7:0] c);
		logic [nsf_pkg::TermW-1:0] ti;
		framer_result_t            r;
		int                        nib;
		bit                        ok;
		case (fr_mode)
			nsf_pkg::MODE_TERM: begin
				if (c == CH_CR || c == CH_LF) begin
					fr_mode = nsf_pkg::MODE_WAIT;
				end else if (fr_wp >= BUF_LEN) begin
					push_status(nsf_pkg::STATUS_OVERFLOW);
				end else if (c == CH_COMMA || c == CH_STAR) begin
					fr_store[fr_wp] = {1'b1, 8'h00};
					fr_wp++;
					if (fr_terms >= TERM_LIMIT) begin
						push_status(nsf_pkg::STATUS_TERMS);
					end else begin
						fr_terms++;
						if (c == CH_STAR) begin
							fr_mode   = nsf_pkg::MODE_CHECK;
							fr_check  = 8'h00;
							fr_digits = 2'd0;
						end else begin
							fr_parity ^= c;
						end
					end
				end else begin
					fr_store[fr_wp] = {1'b0, c};
					fr_wp++;
					fr_parity ^= c;
				end
			end
			nsf_pkg::MODE_CHECK: begin
				if (is_terminator(c)) begin
					ok = (fr_digits == 2'd1 || fr_digits == 2'd2) && fr_check == fr_parity;
					if (!ok) begin
						push_status(nsf_pkg::STATUS_MISMATCH);
					end else begin
						// Good checksum: every stored entry comes back in order.
						fr_mode = nsf_pkg::MODE_WAIT;
						ti = '0;
						for (int i = 0; i < fr_wp; i++) begin
							r.data = fr_store[i][7:0];
							r.term = ti;
							r.sep  = fr_store[i][8];
							r.st   = nsf_pkg::STATUS_BYTE;
							r.last = (i == fr_wp - 1);
							sentence_results.push_back(r);
							if (fr_store[i][8])
								ti++;
						end
					end
				end else if (fr_digits < 2'd2) begin
					nib = hex_nibble(c);
					if (nib >= 0) begin
						fr_check = {fr_check[3:0], nib[3:0]};
						fr_digits++;
					end else begin
						fr_digits = (fr_digits == 2'd0) ? DIGITS_NONE : 2'd2;
					end
				end
			end
			default: begin
				if (c == CH_DOLLAR) begin
					fr_wp     = 0;
					fr_terms  = 0;
					fr_parity = 8'h00;
					fr_mode   = nsf_pkg::MODE_TERM;
				end
			end
		endcase
	endtask

	// Stimulus helpers. Body bytes are folded into the running checksum.
	task automatic send_body(input logic [7:0] c);
		tx_bytes.push_back(c);
		gen_parity ^= c;
	endtask

	function automatic logic [7:0] rand_term_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_terminator(c));
		return c;
	endfunction

	function automatic logic [7:0] rand_terminator();
		case ($urandom_range(0, 3))
			0: return CH_CR;
			1: return CH_LF;
			2: return CH_COMMA;
			default: return CH_STAR;
		endcase
	endfunction

	// One sentence: terms of random bytes, then a checksum field of the given style, or a line end for CK_DROP.
	task automatic queue_sentence(input int commas, input int min_len, input int max_len,
			input check_style_t style);
		logic [7:0] term_char;
		int         len;
		tx_bytes.push_back(CH_DOLLAR);
		gen_parity = 8'h00;
		for (int t = 0; t <= commas; t++) begin
			len = $urandom_range(min_len, max_len);
			for (int k = 0; k < len; k++)
				send_body(rand_term_char());
			if (t < commas)
				send_body(CH_COMMA);
		end
		if (style == CK_DROP) begin
			tx_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
			return;
		end
		tx_bytes.push_back(CH_STAR);
		case (style)
			CK_GOOD_ONE: begin
				tx_bytes.push_back(hex_char(gen_parity[3:0], 1'($urandom_range(0, 1))));
			end
			CK_BAD: begin
				gen_parity ^= 8'($urandom_range(1, 255));
				tx_bytes.push_back(hex_char(gen_parity[7:4], 1'($urandom_range(0, 1))));
				tx_bytes.push_back(hex_char(gen_parity[3:0], 1'($urandom_range(0, 1))));
			end
			CK_NONE: begin
				if ($urandom_range(0, 1)) begin
					do
						term_char = rand_term_char();
					while (hex_nibble(term_char) >= 0);
					tx_bytes.push_back(term_char);
				end
			end
			default: begin
				tx_bytes.push_back(hex_char(gen_parity[7:4], 1'($urandom_range(0, 1))));
				tx_bytes.push_back(hex_char(gen_parity[3:0], 1'($urandom_range(0, 1))));
				// Bytes after two digits are ignored up to the terminator.
				if (style == CK_EXTRA) begin
					repeat ($urandom_range(1, 3))
						tx_bytes.push_back(rand_term_char());
				end
			end
		endcase
		term_char = rand_terminator();
		tx_bytes.push_back(term_char);
		if (term_char == CH_CR && $urandom_range(0, 1))
			tx_bytes.push_back(CH_LF);
	endtask

	// A good sentence that fills the store exactly and reaches the term limit.
	task automatic queue_full_sentence();
		tx_bytes.push_back(CH_DOLLAR);
		gen_parity = 8'h00;
		for (int t = 0; t < TERM_LIMIT; t++) begin
			repeat ((t < BUF_LEN - 2 * TERM_LIMIT) ? 2 : 1)
				send_body(rand_term_char());
			if (t < TERM_LIMIT - 1)
				send_body(CH_COMMA);
		end
		tx_bytes.push_back(CH_STAR);
		tx_bytes.push_back(hex_char(gen_parity[7:4], 1'b1));
		tx_bytes.push_back(hex_char(gen_parity[3:0], 1'b0));
		tx_bytes.push_back(CH_CR);
		tx_bytes.push_back(CH_LF);
	endtask

	task automatic build_stimulus();
		int           sentence_no;
		int           pick;
		check_style_t style;

		// Directed: ignored bytes while waiting, extremes inside a good sentence.
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(CH_COMMA);
		tx_bytes.push_back(CH_STAR);
		tx_bytes.push_back(CH_CR);
		tx_bytes.push_back(CH_DOLLAR);
		gen_parity = 8'h00;
		send_body(8'h00);
		send_body(8'hFF);
		send_body(CH_DOLLAR);
		send_body(CH_COMMA);
		tx_bytes.push_back(CH_STAR);
		tx_bytes.push_back(hex_char(gen_parity[7:4], 1'b0));
		tx_bytes.push_back(hex_char(gen_parity[3:0], 1'b1));
		tx_bytes.push_back(CH_CR);
		tx_bytes.push_back(CH_LF);
		// Line end inside a term drops the sentence.
		tx_bytes.push_back(CH_DOLLAR);
		tx_bytes.push_back("A");
		tx_bytes.push_back(CH_LF);
		// Checksum field closed with no digit.
		tx_bytes.push_back(CH_DOLLAR);
		tx_bytes.push_back("B");
		tx_bytes.push_back(CH_STAR);
		tx_bytes.push_back(CH_COMMA);
		// A single matching digit, closed by a star.
		tx_bytes.push_back(CH_DOLLAR);
		tx_bytes.push_back(8'h05);
		tx_bytes.push_back(CH_STAR);
		tx_bytes.push_back("5");
		tx_bytes.push_back(CH_STAR);

		// Random: mostly well-formed sentences, some broken ones and line noise.
		sentence_no = 0;
		while (tx_bytes.size() < 160 || sentence_no < 6) begin
			case (sentence_no)
				1: queue_sentence(1, 32, 32, CK_GOOD);          // store overflow
				3: queue_sentence(TERM_LIMIT, 0, 0, CK_GOOD);   // too many terms
				5: queue_full_sentence();                       // store full, term limit
				default: begin
					pick = $urandom_range(0, 99);
					if (pick < 55) begin
						case ($urandom_range(0, 2))
							0: style = CK_GOOD;
							1: style = CK_EXTRA;
							default: style = CK_GOOD_ONE;
						endcase
						queue_sentence($urandom_range(0, 5), 0, 6, style);
					end else if (pick < 65) begin
						queue_sentence($urandom_range(0, 5), 0, 6, CK_BAD);
					end else if (pick < 72) begin
						queue_sentence($urandom_range(0, 3), 0, 4, CK_NONE);
					end else if (pick < 80) begin
						queue_sentence($urandom_range(0, 3), 0, 4, CK_DROP);
					end else if (pick < 88) begin
						// Noise, then a line feed brings the framer back to waiting.
						repeat ($urandom_range(1, 6))
							tx_bytes.push_back(8'($urandom_range(0, 255)));
						tx_bytes.push_back(CH_LF);
					end else begin
						queue_sentence($urandom_range(0, 30), 0, 1, CK_GOOD);
					end
				end
			endcase
			sentence_no++;
		end
	endtask

	// Driver: presents queued bytes, with random gaps outside the quiet tail.
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'h00;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				track_sentence_byte(rx_byte);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (tx_bytes.size() == 0) begin
					in_valid <= 1'b0;
				end else if (tx_bytes.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
					gap_left <= $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					rx_byte  <= tx_bytes.pop_front();
				end
			end
		end
	end

	task automatic note_mismatch(input string what, input framer_result_t want,
			input framer_result_t got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display({"%0t: %s: expected data %02h term %0d sep %0b status %0d last %0b,",
				" got data %02h term %0d sep %0b status %0d last %0b"},
				$realtime, what, want.data, want.term, want.sep, want.st, want.last,
				got.data, got.term, got.sep, got.st, got.last);
	endtask

	// Long output hold, counted on its own once enough results have passed.
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= 40) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end
	end

	// Monitor: checks each accepted result and drives the output stall.
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		framer_result_t got;
		framer_result_t want;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{data: out_byte, term: term_index, sep: separator_mark,
					st: nsf_pkg::status_t'(status), last: last};
				results_seen++;
				if (sentence_results.size() == 0) begin
					note_mismatch("unexpected result", '0, got);
				end else begin
					want = sentence_results.pop_front();
					if (got.data !== want.data || got.term !== want.term ||
							got.sep !== want.sep || got.st !== want.st ||
							got.last !== want.last)
						note_mismatch("result mismatch", want, got);
				end
			end

			// One long hold lets the block fill up and push back on its input.
			if (hold_left > 0) begin
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else if (tx_bytes.size() > 0 && $urandom_range(0, 6) == 0) begin
				stall_left <= $urandom_range(0, 3);
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Run control: reset, stimulus, drain and verdict.
	initial begin
		fr_mode   = nsf_pkg::MODE_WAIT;
		fr_wp     = 0;
		fr_terms  = 0;
		fr_parity = 8'h00;
		fr_check  = 8'h00;
		fr_digits = 2'd0;
		build_stimulus();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (tx_bytes.size() != 0 || in_valid);
		while (sentence_results.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);

		if (error_count == 0 && sentence_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#400000;
		$display("Verification failed");
		$finish;
	end

endmodule
